FILE: hw/rtl/bres3_pkg.sv
// ----------------------------------------------------------------------------
// bres3_pkg: shared types and codes for the three-axis line stepper
// Holds the operation codes, the axis code and the result record.
// ----------------------------------------------------------------------------
package bres3_pkg;

  // Operation codes of a command transaction
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic [2:0] step;       // bit 0 = x, bit 1 = y, bit 2 = z
    logic [2:0] dir;        // bit 0 = x, bit 1 = y, bit 2 = z
    logic       move_done;
  } result_t;

endpackage

FILE: hw/rtl/bres3_cmd_if.sv
// ----------------------------------------------------------------------------
// bres3_cmd_if: command channel
// Carries load and tick transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bres3_cmd_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;
  logic signed [COORD_WIDTH-1:0] target_z;

  modport source (
    output valid, operation, target_x, target_y, target_z,
    input  ready
  );
  modport sink (
    input  valid, operation, target_x, target_y, target_z,
    output ready
  );
endinterface

FILE: hw/rtl/bres3_step_if.sv
// ----------------------------------------------------------------------------
// bres3_step_if: step result channel
// Carries step pulses, directions and the done flag with valid/ready.
// ----------------------------------------------------------------------------
interface bres3_step_if;
  logic valid;
  logic ready;
  logic step_x;
  logic step_y;
  logic step_z;
  logic dir_x;
  logic dir_y;
  logic dir_z;
  logic move_done;

  modport source (
    output valid, step_x, step_y, step_z, dir_x, dir_y, dir_z, move_done,
    input  ready
  );
  modport sink (
    input  valid, step_x, step_y, step_z, dir_x, dir_y, dir_z, move_done,
    output ready
  );
endinterface

FILE: hw/rtl/bresenham_3axis_step_generator.sv
// ----------------------------------------------------------------------------
// bresenham_3axis_step_generator: three-axis line step generator
// Loads a relative move and emits one set of step pulses per tick.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - command transactions. operation OP_LOAD takes target_x/y/z as a
//          signed relative move and replaces any move in progress; OP_TICK
//          advances one step on the major axis, plus each minor axis whose
//          error term is non-negative. A tick with no steps left is harmless.
//   step - exactly one result transaction per command: step pulses, the
//          directions of the current move, and move_done once no major steps
//          remain. A load reports no steps.
// An accepted command's result is captured in the output register. Throughput
// is one command per cycle while the skid entry is free: the whole update is a
// few adds and compares on the move state, finished in the accepting cycle.
// Reset clears the move state (idle, directions zero) and empties the output
// stages. When the receiver stalls, the skid entry absorbs one more result;
// cmd.ready drops only while both entries are full.
// ----------------------------------------------------------------------------
module bresenham_3axis_step_generator #(
  parameter int COORD_WIDTH = 16
) (
  input logic          clk,
  input logic          rst,
  bres3_cmd_if.sink    cmd,
  bres3_step_if.source step
);

  logic               accept;
  logic               can_push;
  bres3_pkg::result_t result;

  // Take a command whenever the skid entry is free
  assign cmd.ready = can_push;
  assign accept    = cmd.valid && can_push;

  // Move state and per-transaction update
  bres3_core #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .operation(cmd.operation),
    .target_x (cmd.target_x),
    .target_y (cmd.target_y),
    .target_z (cmd.target_z),
    .result   (result)
  );

  // Output register plus skid stage
  bres3_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(result),
    .can_push (can_push),
    .step     (step)
  );

endmodule

FILE: hw/rtl/bres3_core.sv
// ----------------------------------------------------------------------------
// bres3_core: move state and combinational step update
// Holds deltas, directions, major axis, remaining steps and error terms,
// and forms the result of each accepted transaction.
// ----------------------------------------------------------------------------
module bres3_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          operation,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  input  logic signed [COORD_WIDTH-1:0] target_z,
  output bres3_pkg::result_t            result
);

  localparam int ERR_WIDTH = COORD_WIDTH + 3;

  logic [COORD_WIDTH-1:0]        delta_x, delta_y, delta_z;
  logic [COORD_WIDTH-1:0]        delta_x_next, delta_y_next, delta_z_next;
  logic [2:0]                    dir_bits, dir_bits_next;
  bres3_pkg::axis_t              major_axis, major_axis_next;
  logic [COORD_WIDTH-1:0]        steps_left, steps_left_next;
  logic signed [ERR_WIDTH-1:0]   err_first, err_first_next;
  logic signed [ERR_WIDTH-1:0]   err_second, err_second_next;

  logic [COORD_WIDTH-1:0]        ld_dx, ld_dy, ld_dz;
  logic [2:0]                    ld_dir;
  bres3_pkg::axis_t              ld_major;
  logic [COORD_WIDTH-1:0]        dmaj, d1, d2;
  logic signed [ERR_WIDTH-1:0]   ext_dmaj, two_dmaj, two_d1, two_d2;
  logic                          ge_first, ge_second;
  logic [2:0]                    step_vec;

  function automatic logic [COORD_WIDTH-1:0] mag(input logic [COORD_WIDTH-1:0] v);
    logic [COORD_WIDTH-1:0] neg;
    neg = ~v + {{(COORD_WIDTH-1){1'b0}}, 1'b1};
    return v[COORD_WIDTH-1] ? neg : v;
  endfunction

  function automatic logic is_pos(input logic [COORD_WIDTH-1:0] v);
    return !v[COORD_WIDTH-1] && (v != '0);
  endfunction

  // Decode a load: magnitudes, directions, major axis (x wins ties, then y)
  always_comb begin
    ld_dx  = mag(target_x);
    ld_dy  = mag(target_y);
    ld_dz  = mag(target_z);
    ld_dir = {is_pos(target_z), is_pos(target_y), is_pos(target_x)};
    if (ld_dx >= ld_dy && ld_dx >= ld_dz) begin
      ld_major = bres3_pkg::AXIS_X;
    end else if (ld_dy >= ld_dx && ld_dy >= ld_dz) begin
      ld_major = bres3_pkg::AXIS_Y;
    end else begin
      ld_major = bres3_pkg::AXIS_Z;
    end
  end

  always_comb begin
    delta_x_next    = delta_x;
    delta_y_next    = delta_y;
    delta_z_next    = delta_z;
    dir_bits_next   = dir_bits;
    major_axis_next = major_axis;
    if (accept && operation == bres3_pkg::OP_LOAD) begin
      delta_x_next    = ld_dx;
      delta_y_next    = ld_dy;
      delta_z_next    = ld_dz;
      dir_bits_next   = ld_dir;
      major_axis_next = ld_major;
    end

    // Route deltas by major axis
    unique case (major_axis_next)
      bres3_pkg::AXIS_Y: begin
        dmaj = delta_y_next; d1 = delta_x_next; d2 = delta_z_next;
      end
      bres3_pkg::AXIS_Z: begin
        dmaj = delta_z_next; d1 = delta_y_next; d2 = delta_x_next;
      end
      default: begin
        dmaj = delta_x_next; d1 = delta_y_next; d2 = delta_z_next;
      end
    endcase

    ext_dmaj  = {3'b000, dmaj};
    two_dmaj  = {2'b00, dmaj, 1'b0};
    two_d1    = {2'b00, d1, 1'b0};
    two_d2    = {2'b00, d2, 1'b0};
    ge_first  = !err_first[ERR_WIDTH-1];
    ge_second = !err_second[ERR_WIDTH-1];

    steps_left_next = steps_left;
    err_first_next  = err_first;
    err_second_next = err_second;
    step_vec        = 3'b000;

    if (accept) begin
      if (operation == bres3_pkg::OP_LOAD) begin
        steps_left_next = dmaj;
        err_first_next  = two_d1 - ext_dmaj;
        err_second_next = two_d2 - ext_dmaj;
      end else if (steps_left != '0) begin
        steps_left_next = steps_left - {{(COORD_WIDTH-1){1'b0}}, 1'b1};
        err_first_next  = ge_first  ? err_first - two_dmaj + two_d1 : err_first + two_d1;
        err_second_next = ge_second ? err_second - two_dmaj + two_d2 : err_second + two_d2;
        unique case (major_axis)
          bres3_pkg::AXIS_Y: step_vec = {ge_second, 1'b1, ge_first};
          bres3_pkg::AXIS_Z: step_vec = {1'b1, ge_first, ge_second};
          default:           step_vec = {ge_second, ge_first, 1'b1};
        endcase
      end
    end

    result.step      = step_vec;
    result.dir       = dir_bits_next;
    result.move_done = (steps_left_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_x    <= '0;
      delta_y    <= '0;
      delta_z    <= '0;
      dir_bits   <= '0;
      major_axis <= bres3_pkg::AXIS_X;
      steps_left <= '0;
      err_first  <= '0;
      err_second <= '0;
    end else begin
      delta_x    <= delta_x_next;
      delta_y    <= delta_y_next;
      delta_z    <= delta_z_next;
      dir_bits   <= dir_bits_next;
      major_axis <= major_axis_next;
      steps_left <= steps_left_next;
      err_first  <= err_first_next;
      err_second <= err_second_next;
    end
  end

endmodule

FILE: hw/rtl/bres3_skid.sv
// ----------------------------------------------------------------------------
// bres3_skid: two-entry output register with skid stage
// Registers results and decouples input ready from output ready.
// ----------------------------------------------------------------------------
module bres3_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bres3_pkg::result_t push_data,
  output logic               can_push,
  bres3_step_if.source       step
);

  logic               out_valid;
  bres3_pkg::result_t out_data;
  logic               skid_valid;
  bres3_pkg::result_t skid_data;
  logic               drain;

  assign can_push = !skid_valid;
  assign drain    = !out_valid || step.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: head takes skid first, else the new result; stalled head parks new one
  always_ff @(posedge clk) begin
    if (drain) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign step.valid     = out_valid;
  assign step.step_x    = out_data.step[0];
  assign step.step_y    = out_data.step[1];
  assign step.step_z    = out_data.step[2];
  assign step.dir_x     = out_data.dir[0];
  assign step.dir_y     = out_data.dir[1];
  assign step.dir_z     = out_data.dir[2];
  assign step.move_done = out_data.move_done;

endmodule

FILE: tb/bresenham_3axis_step_generator_tb.sv
// ----------------------------------------------------------------------------
// bresenham_3axis_step_generator_tb: self-checking bench for the line stepper
// Drives load and tick transactions with random gaps and receiver stalls,
// tracks the move state in a scoreboard, and compares every step result.
// ----------------------------------------------------------------------------

class line_step_scoreboard;

  logic [15:0]          mag [3];   // absolute delta per axis, 0 = x, 1 = y, 2 = z
  logic [2:0]           dir_bits;
  bres3_pkg::axis_t     major;
  logic [15:0]          steps_left;
  logic signed [18:0]   err_a;     // first minor axis
  logic signed [18:0]   err_b;     // second minor axis
  bres3_pkg::result_t   pending_steps[$];
  int unsigned          err_count;

  function new();
    mag        = '{16'd0, 16'd0, 16'd0};
    dir_bits   = 3'b000;
    major      = bres3_pkg::AXIS_X;
    steps_left = 16'd0;
    err_a      = 19'sd0;
    err_b      = 19'sd0;
    err_count  = 0;
  endfunction

  function automatic logic signed [18:0] twice(logic [15:0] d);
    return $signed({2'b00, d, 1'b0});
  endfunction

  task report(string msg);
    err_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Advance the tracked move by one accepted command and queue its result.
  function void note_command(logic op, logic signed [15:0] tx,
                             logic signed [15:0] ty, logic signed [15:0] tz);
    logic signed [15:0] t [3];
    bres3_pkg::axis_t   ax_a;
    bres3_pkg::axis_t   ax_b;
    bres3_pkg::result_t r;
    t = '{tx, ty, tz};
    if (op == bres3_pkg::OP_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]      = t[i][15] ? 16'(-t[i]) : 16'(t[i]);
        dir_bits[i] = (t[i] > 0);
      end
      if (mag[0] >= mag[1] && mag[0] >= mag[2]) major = bres3_pkg::AXIS_X;
      else if (mag[1] >= mag[2])                major = bres3_pkg::AXIS_Y;
      else                                      major = bres3_pkg::AXIS_Z;
    end
    ax_a = (major == bres3_pkg::AXIS_Y) ? bres3_pkg::AXIS_X : bres3_pkg::AXIS_Y;
    ax_b = (major == bres3_pkg::AXIS_Z) ? bres3_pkg::AXIS_X : bres3_pkg::AXIS_Z;
    r.step = 3'b000;
    if (op == bres3_pkg::OP_LOAD) begin
      steps_left = mag[major];
      err_a      = twice(mag[ax_a]) - $signed({3'b000, mag[major]});
      err_b      = twice(mag[ax_b]) - $signed({3'b000, mag[major]});
    end else if (steps_left != 16'd0) begin
      r.step[major] = 1'b1;
      if (err_a >= 0) begin
        r.step[ax_a] = 1'b1;
        err_a        = err_a - twice(mag[major]);
      end
      if (err_b >= 0) begin
        r.step[ax_b] = 1'b1;
        err_b        = err_b - twice(mag[major]);
      end
      err_a      = err_a + twice(mag[ax_a]);
      err_b      = err_b + twice(mag[ax_b]);
      steps_left = steps_left - 16'd1;
    end
    r.dir       = dir_bits;
    r.move_done = (steps_left == 16'd0);
    pending_steps.push_back(r);
  endfunction

  task check_step(bres3_pkg::result_t got);
    bres3_pkg::result_t want;
    string              axis_name [3];
    axis_name = '{"x", "y", "z"};
    if (pending_steps.size() == 0) begin
      report("step result with nothing outstanding");
    end else begin
      want = pending_steps.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.step[i] !== want.step[i])
          report($sformatf("step_%s got %b want %b", axis_name[i], got.step[i],
                           want.step[i]));
        if (got.dir[i] !== want.dir[i])
          report($sformatf("dir_%s got %b want %b", axis_name[i], got.dir[i],
                           want.dir[i]));
      end
      if (got.move_done !== want.move_done)
        report($sformatf("move_done got %b want %b", got.move_done, want.move_done));
    end
  endtask

endclass

module bresenham_3axis_step_generator_tb;

  // Cycles with no transaction on either channel before the run is declared hung.
  // The worst legal quiet stretch is the long receiver hold-off plus a random
  // stall streak, well under this.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 60;

  logic clk;
  logic rst;

  bres3_cmd_if #(.COORD_WIDTH(16)) cmd_bus ();
  bres3_step_if                    step_bus ();

  bresenham_3axis_step_generator #(.COORD_WIDTH(16)) uut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_bus),
    .step (step_bus)
  );

  line_step_scoreboard sb;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_req;
  int          items_sent;
  int          quiet_cycles;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Command side: drive at the falling edge, detect acceptance at the rising
  // edge. valid stays high between back-to-back transactions; only an idle
  // gap lowers it.
  // --------------------------------------------------------------------------
  task send_command(logic op, logic signed [15:0] tx, logic signed [15:0] ty,
                    logic signed [15:0] tz);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid = 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid     = 1'b1;
    cmd_bus.operation = op;
    cmd_bus.target_x  = tx;
    cmd_bus.target_y  = ty;
    cmd_bus.target_z  = tz;
    // Hold the transaction until the block takes it.
    do @(posedge clk); while (!cmd_bus.ready);
    sb.note_command(op, tx, ty, tz);
    items_sent++;
    @(negedge clk);
  endtask

  task load_move(logic signed [15:0] tx, logic signed [15:0] ty,
                 logic signed [15:0] tz);
    send_command(bres3_pkg::OP_LOAD, tx, ty, tz);
  endtask

  // Tick payload is ignored by the block; fill it with noise anyway.
  task tick(int count);
    repeat (count)
      send_command(bres3_pkg::OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Mostly short moves so that ticks run them to completion; now and then a
  // full-range or extreme target whose move gets cut short by the next load.
  function automatic logic signed [15:0] pick_target();
    case ($urandom_range(9))
      7:       return 16'($urandom);
      8: begin
        case ($urandom_range(4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return 16'sh0000;
          3:       return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
      9:       return 16'(int'($urandom_range(600)) - 300);
      default: return 16'(int'($urandom_range(24)) - 12);
    endcase
  endfunction

  function automatic int magnitude(logic signed [15:0] v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  // Random moves: a load followed by a run of ticks, with the odd stray tick
  // burst and moves interrupted by a fresh load.
  task run_moves(int count);
    int                 goal;
    int                 ticks;
    int                 longest;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(9) == 0) begin
        ticks = $urandom_range(1, 4);
      end else begin
        tx = pick_target();
        ty = pick_target();
        tz = pick_target();
        load_move(tx, ty, tz);
        longest = magnitude(tx);
        if (magnitude(ty) > longest) longest = magnitude(ty);
        if (magnitude(tz) > longest) longest = magnitude(tz);
        if (longest <= 40 && $urandom_range(7) != 0)
          ticks = longest + $urandom_range(2);
        else
          ticks = $urandom_range(0, (longest < 30) ? longest : 30);
      end
      tick(ticks);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready is redrawn at each falling edge. A hold-off request
  // parks ready low for a long stretch so the skid entry fills and cmd.ready
  // drops while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin
    step_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        step_bus.ready = 1'b0;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(negedge clk);
        hold_off_req = 1'b0;
      end
      step_bus.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    bres3_pkg::result_t got;
    if (!rst && step_bus.valid && step_bus.ready) begin
      got.step      = {step_bus.step_z, step_bus.step_y, step_bus.step_x};
      got.dir       = {step_bus.dir_z, step_bus.dir_y, step_bus.dir_x};
      got.move_done = step_bus.move_done;
      sb.check_step(got);
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (step_bus.valid && step_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bresenham_3axis_step_generator_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb                = new();
    rst               = 1'b1;
    cmd_bus.valid     = 1'b0;
    cmd_bus.operation = bres3_pkg::OP_LOAD;
    cmd_bus.target_x  = '0;
    cmd_bus.target_y  = '0;
    cmd_bus.target_z  = '0;
    send_idle_pct     = 17;
    recv_idle_pct     = 64;
    hold_off_req      = 1'b0;
    items_sent        = 0;
    quiet_cycles      = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed part. Tick straight out of reset: idle, directions zero.
    tick(1);
    // Empty move: done on load, ticks stay idle.
    load_move(16'sd0, 16'sd0, 16'sd0);
    tick(1);
    // Plain x-major move with one minor axis negative, run one tick past the end.
    load_move(16'sd3, -16'sd2, 16'sd1);
    tick(4);
    // y and z tie: y wins over z.
    load_move(16'sd1, 16'sd5, -16'sd5);
    tick(2);
    // Replace a move in progress with a z-major one.
    load_move(-16'sd2, -16'sd2, 16'sd7);
    tick(2);
    // Extremes: most negative target has the largest magnitude, so y leads.
    load_move(16'sh7FFF, 16'sh8000, 16'sd0);
    tick(2);
    // Three-way tie at the most negative value: x wins.
    load_move(16'sh8000, 16'sh8000, 16'sh8000);
    tick(1);
    // Single step on z only.
    load_move(16'sd0, 16'sd0, -16'sd1);
    tick(2);

    run_moves(180);

    send_idle_pct = 64;
    recv_idle_pct = 17;
    run_moves(200);

    // No idling; park the receiver once while the sender streams.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 1'b1;
    run_moves(200);

    cmd_bus.valid = 1'b0;

    // Drain, then give stray results time to show up.
    while (sb.pending_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (sb.err_count == 0) begin
      $display("bresenham_3axis_step_generator_tb: clean");
    end else begin
      $display("bresenham_3axis_step_generator_tb: errors");
    end
    $finish;
  end

endmodule
